// ===== sv/potq_pkg.sv =====
// ============================================================================
// potq_pkg - shared types for the priority ordered task queue
// Command, status and state codes, item structs and the cell-to-cell records.
// ============================================================================
package potq_pkg;

    localparam int FILL_W = 5;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_POP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_PRESENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] task_id;
        logic [7:0] task_priority;
    } request_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        popped_id;
        logic [FILL_W-1:0] fill_count;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] task_id;
        logic [7:0] task_priority;
    } entry_t;

    typedef struct packed {
        op_t        op;
        logic       by_prio;
        logic [7:0] task_id;
        logic [7:0] task_priority;
    } cell_ctrl_t;

    // found: some cell at or before this one holds the id (or a pop is seeded)
    // stop:  the insert slot lies at or before this cell
    typedef struct packed {
        logic found;
        logic stop;
    } chain_t;

endpackage

// ===== sv/priority_ordered_task_queue_core.sv =====
// ============================================================================
// priority_ordered_task_queue_core - ordered ready list of tasks
// Flow: busy is high for the one evaluation cycle, in which the whole cell
//   chain compares and shifts at once; the result is then registered in
//   result_reg and strobed on done from done_reg. A new item can be taken
//   while the last result is strobed, but not while busy.
// Reset: asynchronous, active low; empties the list, no result is pending.
//   The receiver cannot stall, so each result is strobed on done for one cycle only.
// ============================================================================
module priority_ordered_task_queue_core
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  potq_pkg::request_t request,
    output logic               done,
    output potq_pkg::result_t  result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    potq_pkg::state_t    state_reg;
    potq_pkg::state_t    state_next;
    potq_pkg::request_t  req_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                done_reg;
    potq_pkg::result_t   result_reg;
    potq_pkg::result_t   result_next;

    potq_pkg::cell_ctrl_t ctrl;
    potq_pkg::entry_t     cell_q [QUEUE_DEPTH];
    potq_pkg::chain_t     chain  [QUEUE_DEPTH+1];

    logic accept;
    logic any_found;
    logic is_full;
    logic is_empty;

    assign busy   = (state_reg == potq_pkg::ST_EVAL);
    assign accept = start && !busy;

    // The found flag at the tail end tells whether the id is anywhere in the
    // list. The pop seed must not pollute it, but it only matters for add and
    // remove, where the seed is low.
    assign any_found = chain[QUEUE_DEPTH].found;
    assign is_full   = (count_reg == CW'(QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);

    // Seed the chain: a pop behaves as a removal matched at the head.
    assign chain[0].found = busy && (req_reg.cmd == potq_pkg::CMD_POP);
    assign chain[0].stop  = 1'b0;

    // ------------------------------------------------------------------
    // Evaluation: decide the status and what the cells do this cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.op            = potq_pkg::OP_HOLD;
        ctrl.by_prio       = (req_reg.cmd == potq_pkg::CMD_INSERT);
        ctrl.task_id       = req_reg.task_id;
        ctrl.task_priority = req_reg.task_priority;
        count_next         = count_reg;
        result_next.status    = potq_pkg::STAT_OK;
        result_next.popped_id = '0;

        if (busy)
        begin
            case (req_reg.cmd)
                potq_pkg::CMD_APPEND,
                potq_pkg::CMD_INSERT:
                begin
                    // Duplicate check wins over the full check.
                    if (any_found)
                    begin
                        result_next.status = potq_pkg::STAT_PRESENT;
                    end
                    else if (is_full)
                    begin
                        result_next.status = potq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctrl.op    = potq_pkg::OP_ADD;
                        count_next = count_reg + CW'(1);
                    end
                end
                potq_pkg::CMD_REMOVE:
                begin
                    if (any_found)
                    begin
                        ctrl.op    = potq_pkg::OP_DEL;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        result_next.status = potq_pkg::STAT_MISSING;
                    end
                end
                potq_pkg::CMD_POP:
                begin
                    if (is_empty)
                    begin
                        result_next.status = potq_pkg::STAT_MISSING;
                    end
                    else
                    begin
                        ctrl.op               = potq_pkg::OP_DEL;
                        count_next            = count_reg - CW'(1);
                        result_next.popped_id = cell_q[0].task_id;
                    end
                end
                default:
                begin
                    ctrl.op = potq_pkg::OP_HOLD;
                end
            endcase
        end
        result_next.fill_count = potq_pkg::FILL_W'(count_next);
    end

    // ------------------------------------------------------------------
    // Cell chain: slot 0 is the head. Shift-in at the ends reads as empty.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        potq_pkg::entry_t left_entry;
        potq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
        end
        else
        begin : g_mid_l
            assign left_entry = cell_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_mid_r
            assign right_entry = cell_q[i+1];
        end

        potq_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_entry),
            .right     (right_entry),
            .chain_in  (chain[i]),
            .entry     (cell_q[i]),
            .chain_out (chain[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer: idle until an item arrives, then one evaluation cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            potq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = potq_pkg::ST_EVAL;
                end
            end
            potq_pkg::ST_EVAL:
            begin
                state_next = potq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = potq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= potq_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= busy;
        end
    end

    // Hold the command during evaluation; capture the result as it finishes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (busy)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/potq_cell.sv =====
// ============================================================================
// potq_cell - one list slot of the task queue
// Holds one entry and shifts it toward the tail on an add or toward the head
// on a removal, according to the flags rippling along the chain.
// ============================================================================
module potq_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  potq_pkg::cell_ctrl_t  ctrl,
    input  potq_pkg::entry_t      left,
    input  potq_pkg::entry_t      right,
    input  potq_pkg::chain_t      chain_in,
    output potq_pkg::entry_t      entry,
    output potq_pkg::chain_t      chain_out
);

    potq_pkg::entry_t entry_reg;
    potq_pkg::entry_t entry_next;
    logic             my_match;
    logic             my_stop;

    assign my_match = entry_reg.valid && (entry_reg.task_id == ctrl.task_id);
    assign my_stop  = ctrl.by_prio
                    ? !(entry_reg.valid && (entry_reg.task_priority >= ctrl.task_priority))
                    : !entry_reg.valid;

    assign chain_out.found = chain_in.found | my_match;
    assign chain_out.stop  = chain_in.stop | my_stop;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            potq_pkg::OP_ADD:
            begin
                if (chain_in.stop)
                begin
                    entry_next = left;
                end
                else if (my_stop)
                begin
                    entry_next.valid         = 1'b1;
                    entry_next.task_id       = ctrl.task_id;
                    entry_next.task_priority = ctrl.task_priority;
                end
            end
            potq_pkg::OP_DEL:
            begin
                if (chain_in.found || my_match)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== sv/potq_checker.sv =====
// ============================================================================
// potq_checker - port-level checks for the task queue core
// Watches the command and result ports for timing and result consistency.
// ============================================================================
module potq_checker
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input potq_pkg::result_t  result
);

    // An accepted item raises busy in the cycle after the accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // Every accepted item is followed by its result strobe on done.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after accept");

    // A result is only shown once evaluation is over.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // A nonzero popped id only comes with success.
    a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.popped_id != 8'd0)) |-> (result.status == potq_pkg::STAT_OK))
        else $error("popped id on a failed command");

    // A full answer reports the list at its full depth.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == potq_pkg::STAT_FULL))
            |-> (result.fill_count == potq_pkg::FILL_W'(QUEUE_DEPTH)))
        else $error("full status with wrong fill count");

endmodule

bind priority_ordered_task_queue_core potq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_potq_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
